// ===== rtl/core/kmppoc_pkg.sv =====
// Package with the shared types and constants of the KMP occurrence counter.
`default_nettype none
package kmppoc_pkg;

  localparam int CFG_W       = 7;
  localparam int BYTE_W      = 8;
  localparam int OUT_COUNT_W = 16;
  localparam int QUEUE_DEPTH = 4;

  // Classification of one text byte, as handed from the front to the back.
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              last;
    logic              pattern;
    logic              first;
    logic              closing;
    logic              too_short;
  } kmppoc_flags_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_LOOKUP
  } kmppoc_bk_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/kmppoc_in_if.sv =====
// Interface of the text byte channel.
`default_nettype none
interface kmppoc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kmppoc_out_if.sv =====
// Interface of the result channel.
`default_nettype none
interface kmppoc_out_if;
  logic        valid;
  logic        ready;
  logic        match_end;
  logic [15:0] match_count;
  logic        text_too_short;
  logic        last_result;

  modport source (output valid, output match_end, output match_count,
                  output text_too_short, output last_result, input ready);
  modport sink (input valid, input match_end, input match_count,
                input text_too_short, input last_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kmppoc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module kmppoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/kmppoc_front.sv =====
// Front end: accepts text bytes, tracks the position in the text and classifies each byte.
`default_nettype none
module kmppoc_front #(
  parameter int MAX_PATTERN = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [kmppoc_pkg::CFG_W-1:0]  pattern_length,
  kmppoc_in_if.sink                          text,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output logic [$bits(kmppoc_pkg::kmppoc_flags_t)+$clog2(MAX_PATTERN)
                +$clog2(MAX_PATTERN+1)-1:0]  push_data
);

  import kmppoc_pkg::*;

  localparam int AW   = $clog2(MAX_PATTERN);
  localparam int LW   = $clog2(MAX_PATTERN + 1);
  localparam int CMPW = (LW > CFG_W) ? LW : CFG_W;

  logic [LW-1:0]   cnt;
  logic [LW-1:0]   cnt_inc;
  logic [LW-1:0]   alen;
  logic [LW-1:0]   len_cfg;
  logic [LW-1:0]   len_use;
  logic [CMPW-1:0] cfg_ext;
  logic            is_pat;
  logic            accept;
  kmppoc_flags_t   flags;

  // Out-of-range lengths are clamped to the supported span.
  always_comb begin
    cfg_ext = CMPW'(pattern_length);
    if (cfg_ext == '0) begin
      len_cfg = LW'(1);
    end else if (cfg_ext > CMPW'(MAX_PATTERN)) begin
      len_cfg = LW'(MAX_PATTERN);
    end else begin
      len_cfg = LW'(cfg_ext);
    end
  end

  assign len_use = (cnt == '0) ? len_cfg : alen;
  assign cnt_inc = cnt + LW'(1);
  assign is_pat  = cnt < len_use;

  always_comb begin
    flags.text_byte = text.text_byte;
    flags.last      = text.last_byte;
    flags.pattern   = is_pat;
    flags.first     = (cnt == '0);
    flags.closing   = is_pat && (cnt_inc == len_use);
    flags.too_short = text.last_byte && is_pat && (cnt_inc < len_use);
  end

  assign push_data  = {flags, AW'(cnt), len_use};
  assign push_valid = text.valid;
  assign text.ready = push_ready;
  assign accept     = text.valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      alen <= LW'(1);
    end else if (accept) begin
      alen <= len_use;
      if (text.last_byte) begin
        cnt <= '0;
      end else if (is_pat) begin
        cnt <= cnt_inc;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/kmppoc_queue.sv =====
// Short FIFO that decouples the front end from the matching engine.
`default_nettype none
module kmppoc_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/kmppoc_back.sv =====
// Matching engine: builds the failure table and follows failure links one step a cycle.
`default_nettype none
module kmppoc_back #(
  parameter int MAX_PATTERN = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  input  wire logic [$bits(kmppoc_pkg::kmppoc_flags_t)+$clog2(MAX_PATTERN)
                     +$clog2(MAX_PATTERN+1)-1:0] q_data,
  kmppoc_out_if.source                       res
);

  import kmppoc_pkg::*;

  localparam int AW   = $clog2(MAX_PATTERN);
  localparam int LW   = $clog2(MAX_PATTERN + 1);
  localparam int EXTW = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;

  kmppoc_bk_state_t state;
  kmppoc_bk_state_t state_next;

  kmppoc_flags_t    q_flags;
  logic [AW-1:0]    q_idx;
  logic [LW-1:0]    q_len;
  kmppoc_flags_t    ent;
  logic [AW-1:0]    ent_idx;
  logic [LW-1:0]    ent_len;

  logic [AW-1:0]    j;
  logic [AW-1:0]    j_next;
  logic [AW-1:0]    tbl;
  logic [AW-1:0]    m;
  logic [AW-1:0]    tail_fail;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [EXTW-1:0]  cnt_ext;

  logic [BYTE_W-1:0] p_rd;
  logic [AW-1:0]     f_rd;
  logic              match;
  logic              finish;
  logic              out_free;
  logic              done;
  logic              hit;
  logic [LW-1:0]     jf;
  logic [AW-1:0]     fval;

  logic                   o_valid;
  logic                   o_end;
  logic [OUT_COUNT_W-1:0] o_count;
  logic                   o_short;
  logic                   o_last;

  assign {q_flags, q_idx, q_len} = q_data;

  assign out_free = !o_valid || res.ready;
  assign q_pop    = (state == BK_IDLE) && q_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = BK_LOOKUP;
        end
      end
      BK_LOOKUP: begin
        if (done) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    match   = (p_rd == ent.text_byte);
    finish  = ent.first || match || (j == '0);
    done    = (state == BK_LOOKUP) && finish && out_free;
    jf      = (!ent.first && match) ? LW'(j) + LW'(1) : '0;
    fval    = AW'(jf);
    hit     = ent.pattern ? ent.closing : (jf == ent_len);
    cnt_inc = (hit && (cnt != {COUNT_WIDTH{1'b1}})) ? cnt + COUNT_WIDTH'(1) : cnt;
    cnt_ext = EXTW'(cnt_inc);
    j_next  = j;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          j_next = q_flags.pattern ? tbl : m;
        end
      end
      BK_LOOKUP: begin
        if (!finish) begin
          j_next = f_rd;
        end
      end
      default: begin
        j_next = j;
      end
    endcase
  end

  kmppoc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PATTERN)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (q_pop && q_flags.pattern),
    .waddr (q_idx),
    .wdata (q_flags.text_byte),
    .raddr (j_next),
    .rdata (p_rd)
  );

  kmppoc_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_PATTERN)
  ) u_failure_ram (
    .clk   (clk),
    .we    (done && ent.pattern),
    .waddr (ent_idx),
    .wdata (fval),
    .raddr (j_next - AW'(1)),
    .rdata (f_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      tbl     <= '0;
      m       <= '0;
      cnt     <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (done) begin
        o_valid <= 1'b1;
        if (ent.last) begin
          tbl <= '0;
          m   <= '0;
          cnt <= '0;
        end else begin
          if (ent.pattern) begin
            tbl <= fval;
          end
          if (hit) begin
            m <= ent.pattern ? fval : tail_fail;
          end else begin
            m <= AW'(jf);
          end
          cnt <= cnt_inc;
        end
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    j <= j_next;
    if (q_pop) begin
      ent     <= q_flags;
      ent_idx <= q_idx;
      ent_len <= q_len;
    end
    if (done) begin
      o_end   <= hit;
      o_count <= cnt_ext[OUT_COUNT_W-1:0];
      o_short <= ent.too_short;
      o_last  <= ent.last;
      if (ent.pattern && ent.closing) begin
        tail_fail <= fval;
      end
    end
  end

  assign res.valid          = o_valid;
  assign res.match_end      = o_end;
  assign res.match_count    = o_count;
  assign res.text_too_short = o_short;
  assign res.last_result    = o_last;

endmodule
`default_nettype wire

// ===== rtl/core/kmp_prefix_occurrence_counter_core.sv =====
// Top level of the KMP prefix occurrence counter.
//
// Text bytes arrive on text, one per item, with last_byte set on the final
// byte of each text. The first pattern_length bytes of a text are the pattern;
// every byte yields one item on result giving whether an occurrence ends
// there and the saturating running count. The length is written through
// cfg_wr_en and cfg_wr_data and is latched at the first byte of each text.
// A front end classifies each byte and places it in a four-entry queue; the
// matching engine takes one byte at a time and follows one failure link per
// cycle through the pattern and failure RAMs, which are read in parallel.
// The failure links followed are at most one per byte on average over a text.
// Reset empties the queue, clears the position, match length and count, and
// sets the length to one; the RAMs need no clearing. When the receiver stalls,
// the result is held in the output register and the queue fills before
// text deasserts ready.
`default_nettype none
module kmp_prefix_occurrence_counter_core #(
  parameter int MAX_PATTERN = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [kmppoc_pkg::CFG_W-1:0] cfg_wr_data,
  kmppoc_in_if.sink                         text,
  kmppoc_out_if.source                      result
);

  import kmppoc_pkg::*;

  localparam int AW = $clog2(MAX_PATTERN);
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int EW = $bits(kmppoc_flags_t) + AW + LW;

  logic [CFG_W-1:0] pattern_length;
  logic             push_valid;
  logic             push_ready;
  logic [EW-1:0]    push_data;
  logic             pop_valid;
  logic             pop;
  logic [EW-1:0]    pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      pattern_length <= cfg_wr_data;
    end
  end

  kmppoc_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .pattern_length (pattern_length),
    .text           (text),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  kmppoc_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  kmppoc_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_pop   (pop),
    .q_data  (pop_data),
    .res     (result)
  );

endmodule
`default_nettype wire
